@@ rtl/a51_pkg.sv @@
// Package: shared types and constants for the A5/1 keystream generator.
`default_nettype none
package a51_pkg;

    localparam int unsigned LEN1 = 19;
    localparam int unsigned LEN2 = 22;
    localparam int unsigned LEN3 = 23;
    localparam int unsigned KEY_W = 64;
    localparam int unsigned FRAME_W = 22;
    localparam int unsigned CNT_W = 7;

    localparam logic [LEN1-1:0] TAPS1 = 19'h7_2000;
    localparam logic [LEN2-1:0] TAPS2 = 22'h30_0000;
    localparam logic [LEN3-1:0] TAPS3 = 23'h70_0080;

    localparam int unsigned CLK1_BIT = 8;
    localparam int unsigned CLK2_BIT = 10;
    localparam int unsigned CLK3_BIT = 10;

    localparam logic [CNT_W-1:0] KEY_LAST = 7'd63;
    localparam logic [CNT_W-1:0] FRAME_LAST = 7'd21;
    localparam logic [CNT_W-1:0] WARM_LAST = 7'd99;

    localparam logic OP_INIT = 1'b0;
    localparam logic OP_GEN = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [21:0] frame_number;
    } t_in_item;

    typedef struct packed {
        logic keystream_bit;
        logic first_top_bit;
        logic second_top_bit;
        logic third_top_bit;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_FRAME,
        ST_WARM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             clear;
        logic             clock_all;
        logic             sel_key;
        logic             majority;
        logic             out_load;
        logic [CNT_W-1:0] idx;
    } t_dp_cmd;

endpackage
`default_nettype wire

@@ rtl/a51_datapath.sv @@
// Datapath: session key, frame latch, the three shift registers and the result register.
`default_nettype none
module a51_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [63:0]       i_cfg_data,
    input  wire a51_pkg::t_in_item i_in,
    input  wire a51_pkg::t_dp_cmd  i_cmd,
    output a51_pkg::t_out_item     o_out
);

    logic [a51_pkg::KEY_W-1:0]   r_key;
    logic [a51_pkg::FRAME_W-1:0] r_frame;
    logic [a51_pkg::LEN1-1:0]    r_sr1, n_sr1;
    logic [a51_pkg::LEN2-1:0]    r_sr2, n_sr2;
    logic [a51_pkg::LEN3-1:0]    r_sr3, n_sr3;
    a51_pkg::t_out_item          r_out;

    logic mix;
    logic fb1, fb2, fb3;
    logic c1, c2, c3, maj;

    always_comb begin
        if (i_cmd.sel_key) begin
            mix = r_key[i_cmd.idx[5:0]];
        end else begin
            mix = r_frame[i_cmd.idx[4:0]];
        end
        mix = mix & i_cmd.clock_all;
        fb1 = (^(r_sr1 & a51_pkg::TAPS1)) ^ mix;
        fb2 = (^(r_sr2 & a51_pkg::TAPS2)) ^ mix;
        fb3 = (^(r_sr3 & a51_pkg::TAPS3)) ^ mix;
        c1  = r_sr1[a51_pkg::CLK1_BIT];
        c2  = r_sr2[a51_pkg::CLK2_BIT];
        c3  = r_sr3[a51_pkg::CLK3_BIT];
        maj = (c1 & c2) | (c1 & c3) | (c2 & c3);

        n_sr1 = r_sr1;
        n_sr2 = r_sr2;
        n_sr3 = r_sr3;
        if (i_cmd.clear) begin
            n_sr1 = '0;
            n_sr2 = '0;
            n_sr3 = '0;
        end else if (i_cmd.clock_all) begin
            n_sr1 = {r_sr1[a51_pkg::LEN1-2:0], fb1};
            n_sr2 = {r_sr2[a51_pkg::LEN2-2:0], fb2};
            n_sr3 = {r_sr3[a51_pkg::LEN3-2:0], fb3};
        end else if (i_cmd.majority) begin
            if (c1 == maj) begin
                n_sr1 = {r_sr1[a51_pkg::LEN1-2:0], fb1};
            end
            if (c2 == maj) begin
                n_sr2 = {r_sr2[a51_pkg::LEN2-2:0], fb2};
            end
            if (c3 == maj) begin
                n_sr3 = {r_sr3[a51_pkg::LEN3-2:0], fb3};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_sr1 <= '0;
            r_sr2 <= '0;
            r_sr3 <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key <= i_cfg_data;
            end
            r_sr1 <= n_sr1;
            r_sr2 <= n_sr2;
            r_sr3 <= n_sr3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_frame <= i_in.frame_number;
        end
        if (i_cmd.out_load) begin
            r_out.first_top_bit  <= n_sr1[a51_pkg::LEN1-1];
            r_out.second_top_bit <= n_sr2[a51_pkg::LEN2-1];
            r_out.third_top_bit  <= n_sr3[a51_pkg::LEN3-1];
            r_out.keystream_bit  <= n_sr1[a51_pkg::LEN1-1] ^ n_sr2[a51_pkg::LEN2-1]
                                    ^ n_sr3[a51_pkg::LEN3-1];
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

@@ rtl/a51_controller.sv @@
// Controller: sequences initialization, issues datapath commands, owns the handshakes.
`default_nettype none
module a51_controller (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_opcode,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output a51_pkg::t_dp_cmd o_cmd
);

    a51_pkg::t_state             r_state, n_state;
    logic [a51_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    logic                        slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= a51_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        slot_free   = !r_out_valid || !i_out_stall;
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b1;
        o_cmd       = '0;
        o_cmd.idx   = r_count;
        unique case (r_state)
            a51_pkg::ST_IDLE: begin
                o_in_stall = !slot_free;
                if (i_in_valid && slot_free) begin
                    if (i_in_opcode == a51_pkg::OP_GEN) begin
                        o_cmd.majority = 1'b1;
                        o_cmd.out_load = 1'b1;
                        n_out_valid    = 1'b1;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_count     = '0;
                        n_state     = a51_pkg::ST_KEY;
                    end
                end
            end
            a51_pkg::ST_KEY: begin
                o_cmd.clock_all = 1'b1;
                o_cmd.sel_key   = 1'b1;
                if (r_count == a51_pkg::KEY_LAST) begin
                    n_count = '0;
                    n_state = a51_pkg::ST_FRAME;
                end else begin
                    n_count = r_count + a51_pkg::CNT_W'(1);
                end
            end
            a51_pkg::ST_FRAME: begin
                o_cmd.clock_all = 1'b1;
                if (r_count == a51_pkg::FRAME_LAST) begin
                    n_count = '0;
                    n_state = a51_pkg::ST_WARM;
                end else begin
                    n_count = r_count + a51_pkg::CNT_W'(1);
                end
            end
            a51_pkg::ST_WARM: begin
                o_cmd.majority = 1'b1;
                if (r_count == a51_pkg::WARM_LAST) begin
                    n_count = '0;
                    n_state = a51_pkg::ST_DONE;
                end else begin
                    n_count = r_count + a51_pkg::CNT_W'(1);
                end
            end
            a51_pkg::ST_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = a51_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = a51_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ rtl/a51_keystream_generator.sv @@
// Top level: A5/1 keystream generator, controller plus datapath.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | i_in  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (64-bit session key)
//
// A generate transaction's result is registered at the accept edge, so generate
// transactions stream one per cycle while the output is not stalled.
// An initialize transaction is run one step per cycle by the load sequencer: 64 key clocks,
// 22 frame clocks, 100 warm-up steps, then the result load once the result slot is free.
// Synchronous reset clears the shift registers and the key; no clearing pass.
// A stalled output holds its result; the input stalls while the result slot is full or an initialization runs.
`default_nettype none
module a51_keystream_generator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire a51_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output a51_pkg::t_out_item     o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [63:0]       i_cfg_data
);

    a51_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    a51_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_opcode (i_in.opcode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    a51_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for the A5/1 keystream generator: directed table, random phases, predictor check.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DIR_N          = 22;
    localparam int          PHASE_ITEMS    = 226;
    localparam int          HOLDOFF_CYCLES = 200;
    localparam int          SETTLE_CYCLES  = 200;
    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam logic [63:0] KEY_ZERO       = 64'h0;
    localparam logic [63:0] KEY_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_MIX        = 64'h0123_4567_89AB_CDEF;
    localparam logic [21:0] FRAME_MAX      = 22'h3F_FFFF;
    localparam logic [22:0] R1_TAPS        = 23'h07_2000;
    localparam logic [22:0] R2_TAPS        = 23'h30_0000;
    localparam logic [22:0] R3_TAPS        = 23'h70_0080;
    localparam logic [22:0] R1_MASK        = 23'h07_FFFF;
    localparam logic [22:0] R2_MASK        = 23'h3F_FFFF;
    localparam logic [22:0] R3_MASK        = 23'h7F_FFFF;

    typedef struct packed {
        logic                set_key;
        logic [63:0]         key;
        a51_pkg::t_in_item   item;
        logic                fixed;
        a51_pkg::t_out_item  result;
    } t_dir_row;

    t_dir_row directed_rows [0:DIR_N-1] = '{
        '{1'b0, KEY_ZERO, '{a51_pkg::OP_GEN,  22'd0},        1'b1, '0},
        '{1'b0, KEY_ZERO, '{a51_pkg::OP_GEN,  FRAME_MAX},    1'b1, '0},
        '{1'b1, KEY_ZERO, '{a51_pkg::OP_INIT, 22'd0},        1'b1, '0},
        '{1'b0, KEY_ZERO, '{a51_pkg::OP_GEN,  FRAME_MAX},    1'b1, '0},
        '{1'b0, KEY_ZERO, '{a51_pkg::OP_INIT, FRAME_MAX},    1'b0, '0},
        '{1'b0, KEY_ZERO, '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b0, KEY_ZERO, '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b0, KEY_ZERO, '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b1, KEY_ONES, '{a51_pkg::OP_INIT, 22'd0},        1'b0, '0},
        '{1'b0, KEY_ONES, '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b0, KEY_ONES, '{a51_pkg::OP_GEN,  FRAME_MAX},    1'b0, '0},
        '{1'b0, KEY_ONES, '{a51_pkg::OP_INIT, FRAME_MAX},    1'b0, '0},
        '{1'b0, KEY_ONES, '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b0, KEY_ONES, '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b1, KEY_MIX,  '{a51_pkg::OP_INIT, 22'h00_0134},  1'b0, '0},
        '{1'b0, KEY_MIX,  '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b0, KEY_MIX,  '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b0, KEY_MIX,  '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b0, KEY_MIX,  '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0},
        '{1'b0, KEY_MIX,  '{a51_pkg::OP_INIT, 22'h2A_AAAA},  1'b0, '0},
        '{1'b0, KEY_MIX,  '{a51_pkg::OP_INIT, 22'h15_5555},  1'b0, '0},
        '{1'b0, KEY_MIX,  '{a51_pkg::OP_GEN,  22'd0},        1'b0, '0}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    a51_pkg::t_in_item  i_in        = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [63:0]        i_cfg_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    a51_pkg::t_out_item o_out;
    logic               o_cfg_ready;

    logic               row_fixed     = 1'b0;
    a51_pkg::t_out_item row_fixed_val = '0;

    logic [63:0] key_copy = '0;
    logic [22:0] lfsr1    = '0;
    logic [22:0] lfsr2    = '0;
    logic [22:0] lfsr3    = '0;

    a51_pkg::t_out_item keystream_q [$];
    int          error_count      = 0;
    int          cycle_count      = 0;
    int          send_idle_pct    = 0;
    int          recv_idle_pct    = 0;
    int          holdoff_requests = 0;
    int          holdoff_served   = 0;
    int          holdoff_left     = 0;

    a51_keystream_generator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [22:0] lfsr_shift(input logic [22:0] r, input logic [22:0] taps,
                                               input logic [22:0] mask, input logic mix);
        return ((r << 1) | {22'd0, (^(r & taps)) ^ mix}) & mask;
    endfunction

    task automatic clock_all_lfsrs(input logic mix);
        lfsr1 = lfsr_shift(lfsr1, R1_TAPS, R1_MASK, mix);
        lfsr2 = lfsr_shift(lfsr2, R2_TAPS, R2_MASK, mix);
        lfsr3 = lfsr_shift(lfsr3, R3_TAPS, R3_MASK, mix);
    endtask

    task automatic majority_clock();
        logic c1;
        logic c2;
        logic c3;
        logic maj;
        c1  = lfsr1[8];
        c2  = lfsr2[10];
        c3  = lfsr3[10];
        maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
        if (c1 == maj) lfsr1 = lfsr_shift(lfsr1, R1_TAPS, R1_MASK, 1'b0);
        if (c2 == maj) lfsr2 = lfsr_shift(lfsr2, R2_TAPS, R2_MASK, 1'b0);
        if (c3 == maj) lfsr3 = lfsr_shift(lfsr3, R3_TAPS, R3_MASK, 1'b0);
    endtask

    task automatic predict_keystream(input a51_pkg::t_in_item it,
                                     output a51_pkg::t_out_item res);
        if (it.opcode == a51_pkg::OP_INIT) begin
            lfsr1 = '0;
            lfsr2 = '0;
            lfsr3 = '0;
            for (int i = 0; i < 64; i++) clock_all_lfsrs(key_copy[i]);
            for (int i = 0; i < 22; i++) clock_all_lfsrs(it.frame_number[i]);
            for (int i = 0; i < 100; i++) majority_clock();
        end else begin
            majority_clock();
        end
        res.first_top_bit  = lfsr1[18];
        res.second_top_bit = lfsr2[21];
        res.third_top_bit  = lfsr3[22];
        res.keystream_bit  = lfsr1[18] ^ lfsr2[21] ^ lfsr3[22];
    endtask

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic a51_pkg::t_in_item random_item(input logic op);
        a51_pkg::t_in_item it;
        int                pick;
        pick = $urandom_range(7);
        it.opcode = op;
        if (pick == 0) it.frame_number = '0;
        else if (pick == 1) it.frame_number = FRAME_MAX;
        else it.frame_number = 22'($urandom());
        return it;
    endfunction

    task automatic send_item(input a51_pkg::t_in_item it, input logic fixed,
                             input a51_pkg::t_out_item fixed_val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in          <= it;
        row_fixed     <= fixed;
        row_fixed_val <= fixed_val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (keystream_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_key(input logic [63:0] k);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input logic [63:0] k,
                             input bit holdoff);
        int sent;
        int burst;
        drain();
        write_key(k);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (holdoff) holdoff_requests++;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(9) < 8) begin
                send_item(random_item(a51_pkg::OP_INIT), 1'b0, '0);
                burst = $urandom_range(40, 4);
                repeat (burst) send_item(random_item(a51_pkg::OP_GEN), 1'b0, '0);
                sent += burst + 1;
            end else begin
                burst = $urandom_range(6, 1);
                repeat (burst)
                    send_item(random_item($urandom_range(1) ? a51_pkg::OP_GEN
                                                            : a51_pkg::OP_INIT),
                              1'b0, '0);
                sent += burst;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (holdoff_left != 0) begin
            i_out_stall  <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_served != holdoff_requests) begin
            holdoff_served <= holdoff_requests;
            holdoff_left   <= HOLDOFF_CYCLES;
            i_out_stall    <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) key_copy = i_cfg_data;
    end

    always @(posedge i_clk) begin : in_monitor
        a51_pkg::t_out_item predicted;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_keystream(i_in, predicted);
            keystream_q.push_back(row_fixed ? row_fixed_val : predicted);
        end
    end

    always @(posedge i_clk) begin : out_check
        a51_pkg::t_out_item exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (keystream_q.size() == 0) begin
                report_error("result transaction with nothing expected");
            end else begin
                exp_res = keystream_q.pop_front();
                if (o_out.keystream_bit !== exp_res.keystream_bit)
                    report_error($sformatf("keystream_bit exp %0b got %0b",
                                           exp_res.keystream_bit, o_out.keystream_bit));
                if (o_out.first_top_bit !== exp_res.first_top_bit)
                    report_error($sformatf("first_top_bit exp %0b got %0b",
                                           exp_res.first_top_bit, o_out.first_top_bit));
                if (o_out.second_top_bit !== exp_res.second_top_bit)
                    report_error($sformatf("second_top_bit exp %0b got %0b",
                                           exp_res.second_top_bit, o_out.second_top_bit));
                if (o_out.third_top_bit !== exp_res.third_top_bit)
                    report_error($sformatf("third_top_bit exp %0b got %0b",
                                           exp_res.third_top_bit, o_out.third_top_bit));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (directed_rows[i].set_key) begin
                drain();
                write_key(directed_rows[i].key);
            end
            send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].result);
        end

        run_phase(37, 77, {$urandom(), $urandom()}, 1'b1);
        run_phase(77, 37, {$urandom(), $urandom()}, 1'b0);
        run_phase(0, 0, {$urandom(), $urandom()}, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
